// ===== sv/daily_temperature_stats_alarm_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the daily temperature statistics block
// Clocked implication checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef DAILY_TEMPERATURE_STATS_ALARM_ASSERT_SVH
`define DAILY_TEMPERATURE_STATS_ALARM_ASSERT_SVH

// Same-cycle implication: when a holds, c holds at the same edge.
`define DTS_ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("dts assertion failed");

// Next-cycle implication: when a holds, c holds at the following edge.
`define DTS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("dts assertion failed");

`endif

// ===== sv/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the daily temperature statistics block.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int NUM_DAYS_DEF = 7;

    localparam int TICK_W  = 17;
    localparam int DAY_W   = 3;
    localparam int TEMP_W  = 14;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // ticks * 16 / 210 equals ticks * 8 / 105. The quotient is estimated with
    // a reciprocal multiply (2^27 / 105, rounded down) and corrected once.
    localparam int RECIP_S = 24;
    localparam int RECIP_W = 21;
    localparam int RECIP_M = (1 << (RECIP_S + 3)) / 105;
    localparam int TICKS_DIV = 105;
    localparam int PROD_W  = TICK_W + RECIP_W;
    localparam int REM_W   = TICK_W + 4;

    // 273.15 degrees in 1/16 units, truncated.
    localparam int KELVIN_OFFSET = 4370;
    // 500 degrees in 1/16 units, the starting minimum of a fresh day.
    localparam int FIRST_MIN = 8000;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIM = 2'd2;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_COLD  = 2'd1,
        EV_HOT   = 2'd2,
        EV_CLEAR = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_UPD,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  min_v;
        logic signed [TEMP_W-1:0]  max_v;
        logic signed [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0]        count;
    } t_day_rec;

    // Start request from the update step to the average divider.
    typedef struct packed {
        logic                start;
        logic                neg;
        logic [TOTAL_W-1:0]  magnitude;
        logic [COUNT_W-1:0]  divisor;
    } t_div_req;

endpackage

// ===== sv/daily_temperature_stats_alarm.sv =====
// ----------------------------------------------------------------------------
// daily_temperature_stats_alarm
// Pulse-width temperature conversion, per-day statistics and threshold alarm.
// ----------------------------------------------------------------------------
// Each store item carries a sensor pulse width in timer ticks, which the block
// converts to 1/16 degree Celsius as floor(ticks * 16 / 210) - 4370, and then
// folds into the record of the addressed day: minimum, maximum, running total
// and a sample count that saturates at 65535 (the total freezes with it). The
// result item reports the converted value, the updated minimum and maximum,
// the average (total over count, truncated toward zero), the count and an
// alarm event. With the alarm enabled, a value below the low limit or above
// the high limit raises one event and sets a latch; the latch clears, with its
// own event, once a value lies strictly between the limits. A clear item
// zeroes every day record but keeps the alarm latch, and returns all zeros. A
// day index at or beyond the number of days stores nothing and reports only
// the temperature. Timing: the block works on one item at a time. A store item
// to a day in range passes through the conversion, the update and the 32-step
// bit-serial average divider before its result is loaded; when the output
// register is free, the input is ready again in the same cycle as the result
// turns valid. A clear item goes from acceptance straight to the output load
// and a store to a day out of range through conversion and update. The result
// sits in an output register, so the next item is accepted while the previous
// result still waits; a second finished item then holds the input off until
// the first result is taken. Day records live in one memory with a registered
// read and per-day valid bits, so reset and clear take effect at once, with
// no clearing pass. Configuration writes are taken at any edge with the write
// enable high and are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
module daily_temperature_stats_alarm
    import dts_pkg::*;
#(
    parameter int NUM_DAYS = NUM_DAYS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_opcode,
    input  logic [DAY_W-1:0]          i_day_index,
    input  logic [TICK_W-1:0]         i_pulse_ticks,
    // Result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [TEMP_W-1:0]  o_temp_value,
    output logic signed [TEMP_W-1:0]  o_day_min,
    output logic signed [TEMP_W-1:0]  o_day_max,
    output logic signed [TEMP_W-1:0]  o_day_average,
    output logic [COUNT_W-1:0]        o_day_count,
    output logic [1:0]                o_warning_event
);

    localparam int AW = (NUM_DAYS > 1) ? $clog2(NUM_DAYS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                      r_alarm_en;
    logic signed [TEMP_W-1:0]  r_low_lim;
    logic signed [TEMP_W-1:0]  r_high_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_en <= 1'b0;
            r_low_lim  <= '0;
            r_high_lim <= TEMP_W'(400);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALARM_EN: r_alarm_en <= i_cfg_data[0];
                CFG_LOW_LIM:  r_low_lim  <= $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_HIGH_LIM: r_high_lim <= $signed(i_cfg_data[TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state  r_state, n_state;
    logic    in_fire;
    logic    out_load;
    logic    div_done;

    logic    r_op;
    logic    r_day_ok;
    logic [AW-1:0] r_addr;
    logic [TICK_W-1:0] r_ticks;
    logic    r_latch;
    logic    r_out_valid;

    logic    day_ok_in;
    logic [AW-1:0] addr_in;

    assign day_ok_in = (32'(i_day_index) < NUM_DAYS);
    assign addr_in   = AW'(i_day_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_CLEAR) ? S_FIN : S_CONV;
                end
            end
            S_CONV: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = r_day_ok ? S_DIV : S_FIN;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // The output register frees up in the same cycle it is taken.
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign in_fire = o_in_ready && i_in_valid;

    // ------------------------------------------------------------------
    // Day record memory with per-day valid bits. An entry that is not
    // valid reads as an empty record. The write happens in the update
    // step and the next read only at a later acceptance, so no two
    // accesses to one entry ever overlap.
    // ------------------------------------------------------------------
    t_day_rec            r_mem [NUM_DAYS];
    t_day_rec            r_rd;
    logic                r_rd_vld;
    logic [NUM_DAYS-1:0] r_valid;
    t_day_rec            wr_rec;
    logic                wr_en;

    always_ff @(posedge i_clk) begin
        if (in_fire && day_ok_in) begin
            r_rd     <= r_mem[addr_in];
            r_rd_vld <= r_valid[addr_in];
        end
        if (wr_en) begin
            r_mem[r_addr] <= wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (in_fire && (i_opcode == OP_CLEAR)) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Conversion: reciprocal product registered at acceptance, then one
    // remainder check bumps the estimate by one where needed.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]         r_prod;
    logic signed [TEMP_W-1:0]  r_temp;
    logic [TEMP_W-1:0]         q_est;
    logic [REM_W-1:0]          q_rem;
    logic [TEMP_W-1:0]         q_fix;
    logic [TEMP_W:0]           temp_wide;

    assign q_est = r_prod[RECIP_S +: TEMP_W];
    assign q_rem = REM_W'({r_ticks, 3'b000}) - REM_W'(REM_W'(q_est) * REM_W'(TICKS_DIV));
    assign q_fix = (q_rem >= REM_W'(TICKS_DIV)) ? q_est + 1'b1 : q_est;
    assign temp_wide = {1'b0, q_fix} - (TEMP_W + 1)'(KELVIN_OFFSET);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= i_opcode;
            r_day_ok <= day_ok_in;
            r_addr   <= addr_in;
            r_ticks  <= i_pulse_ticks;
            r_prod   <= PROD_W'(i_pulse_ticks) * PROD_W'(RECIP_M);
        end
        if (r_state == S_CONV) begin
            r_temp <= $signed(temp_wide[TEMP_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Update step: read-modify-write of the day record and alarm check.
    // ------------------------------------------------------------------
    t_day_rec                  old_rec;
    logic signed [TEMP_W-1:0]  base_min;
    logic signed [TEMP_W-1:0]  base_max;
    logic signed [TEMP_W-1:0]  new_min;
    logic signed [TEMP_W-1:0]  new_max;
    logic signed [TOTAL_W-1:0] new_total;
    logic [COUNT_W-1:0]        new_count;
    t_event                    ev;
    logic                      n_latch;
    t_div_req                  div_req;

    always_comb begin
        old_rec = r_rd_vld ? r_rd : '0;
        // A day without samples starts from a 500 degree minimum and zero max.
        if (old_rec.count == '0) begin
            base_min = TEMP_W'(FIRST_MIN);
            base_max = '0;
        end else begin
            base_min = old_rec.min_v;
            base_max = old_rec.max_v;
        end
        new_max = (r_temp > base_max) ? r_temp : base_max;
        new_min = (r_temp < base_min) ? r_temp : base_min;
        if (old_rec.count < COUNT_W'(COUNT_MAX)) begin
            new_total = old_rec.total + TOTAL_W'(r_temp);
            new_count = old_rec.count + 1'b1;
        end else begin
            new_total = old_rec.total;
            new_count = old_rec.count;
        end

        ev      = EV_NONE;
        n_latch = r_latch;
        if (r_alarm_en) begin
            if ((r_temp < r_low_lim) && !r_latch) begin
                ev      = EV_COLD;
                n_latch = 1'b1;
            end else if ((r_temp > r_high_lim) && !r_latch) begin
                ev      = EV_HOT;
                n_latch = 1'b1;
            end else if (r_latch && (r_temp < r_high_lim) && (r_temp > r_low_lim)) begin
                ev      = EV_CLEAR;
                n_latch = 1'b0;
            end
        end

        wr_en         = (r_state == S_UPD) && r_day_ok;
        wr_rec.min_v  = new_min;
        wr_rec.max_v  = new_max;
        wr_rec.total  = new_total;
        wr_rec.count  = new_count;

        div_req.start     = wr_en;
        div_req.neg       = new_total[TOTAL_W-1];
        div_req.magnitude = new_total[TOTAL_W-1] ? TOTAL_W'(-new_total)
                                                 : TOTAL_W'(new_total);
        div_req.divisor   = new_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= 1'b0;
        end else if (wr_en) begin
            r_latch <= n_latch;
        end
    end

    // Day results held until the average is ready.
    logic signed [TEMP_W-1:0] r_res_min;
    logic signed [TEMP_W-1:0] r_res_max;
    logic [COUNT_W-1:0]       r_res_count;
    t_event                   r_res_ev;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_res_min   <= new_min;
            r_res_max   <= new_max;
            r_res_count <= new_count;
            r_res_ev    <= ev;
        end
    end

    logic signed [TEMP_W-1:0] div_avg;

    dts_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .o_done    (div_done),
        .o_average (div_avg)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0] r_out_temp;
    logic signed [TEMP_W-1:0] r_out_min;
    logic signed [TEMP_W-1:0] r_out_max;
    logic signed [TEMP_W-1:0] r_out_avg;
    logic [COUNT_W-1:0]       r_out_count;
    t_event                   r_out_ev;
    logic                     day_fields;

    // Day fields are reported only for a store to a day in range.
    assign day_fields = (r_op == OP_STORE) && r_day_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_temp  <= (r_op == OP_STORE) ? r_temp : '0;
            r_out_min   <= day_fields ? r_res_min : '0;
            r_out_max   <= day_fields ? r_res_max : '0;
            r_out_avg   <= day_fields ? div_avg : '0;
            r_out_count <= day_fields ? r_res_count : '0;
            r_out_ev    <= day_fields ? r_res_ev : EV_NONE;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_temp_value    = r_out_temp;
    assign o_day_min       = r_out_min;
    assign o_day_max       = r_out_max;
    assign o_day_average   = r_out_avg;
    assign o_day_count     = r_out_count;
    assign o_warning_event = r_out_ev;

endmodule

// ===== sv/dts_div.sv =====
// ----------------------------------------------------------------------------
// dts_div
// Bit-serial restoring divider: signed day total over the sample count.
// ----------------------------------------------------------------------------
module dts_div
    import dts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_div_req                 i_req,
    output logic                     o_done,
    output logic signed [TEMP_W-1:0] o_average
);

    localparam int CNT_W = $clog2(TOTAL_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [TOTAL_W-1:0]  r_quo;
    logic [COUNT_W-1:0]  r_rem;
    logic [COUNT_W-1:0]  r_div;
    logic                r_neg;

    logic [COUNT_W:0]    rem_sh;
    logic                fits;
    logic [COUNT_W:0]    rem_sub;
    logic [TEMP_W-1:0]   quo_lo;

    // The dividend shifts out of r_quo while quotient bits shift in.
    assign rem_sh  = {r_rem, r_quo[TOTAL_W-1]};
    assign fits    = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign quo_lo  = r_quo[TEMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TOTAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.magnitude;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_quo <= {r_quo[TOTAL_W-2:0], fits};
            r_rem <= fits ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        end
    end

    // The average magnitude never exceeds the largest sample magnitude.
    assign o_done    = r_done;
    assign o_average = r_neg ? -$signed(quo_lo) : $signed(quo_lo);

endmodule

// ===== sv/dts_checker.sv =====
// ----------------------------------------------------------------------------
// dts_checker
// Port-level checks of the daily temperature statistics block.
// ----------------------------------------------------------------------------
`include "daily_temperature_stats_alarm_assert.svh"

module dts_checker
    import dts_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      o_in_ready,
    input  logic                      i_opcode,
    input  logic [DAY_W-1:0]          i_day_index,
    input  logic [TICK_W-1:0]         i_pulse_ticks,
    input  logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [TEMP_W-1:0]  o_temp_value,
    input  logic signed [TEMP_W-1:0]  o_day_min,
    input  logic signed [TEMP_W-1:0]  o_day_max,
    input  logic signed [TEMP_W-1:0]  o_day_average,
    input  logic [COUNT_W-1:0]        o_day_count,
    input  logic [1:0]                o_warning_event
);

    logic                          in_waiting;
    logic [TICK_W+DAY_W:0]         in_word;
    logic                          stalled;
    logic [4*TEMP_W+COUNT_W+1:0]   out_word;
    logic                          empty_day;
    logic                          empty_ok;
    logic                          counted_day;
    logic                          day_ordered;

    // An offered item keeps its payload until the block takes it.
    assign in_waiting = i_in_valid && !o_in_ready;
    assign in_word    = {i_opcode, i_day_index, i_pulse_ticks};

    assign stalled  = o_out_valid && !i_out_ready;
    assign out_word = {o_temp_value, o_day_min, o_day_max, o_day_average,
                       o_day_count, o_warning_event};

    // A result with no samples comes from a clear or a day out of range.
    assign empty_day = o_out_valid && (o_day_count == '0);
    assign empty_ok  = (o_day_min == '0) && (o_day_max == '0) &&
                       (o_day_average == '0) && (o_warning_event == EV_NONE);

    assign counted_day = o_out_valid && (o_day_count != '0);
    assign day_ordered = (o_day_min <= o_day_max);

    `DTS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_waiting, i_in_valid && $stable(in_word))
    `DTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(out_word))
    `DTS_ASSERT_SAME(a_empty_day, i_clk, i_rst_n, empty_day, empty_ok)
    `DTS_ASSERT_SAME(a_min_le_max, i_clk, i_rst_n, counted_day, day_ordered)

endmodule

bind daily_temperature_stats_alarm dts_checker u_dts_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for daily_temperature_stats_alarm
// Drives sensor samples and clear items through the valid/ready channels,
// predicts every result item from a model of the day records and the alarm
// latch, and compares the block's results field by field, in order.
// ----------------------------------------------------------------------------
module testbench
    import dts_pkg::*;
();

    // 210 timer ticks make one kelvin.
    localparam int TICKS_PER_KELVIN = 210;
    // Random store items per phase, items to days out of range not counted.
    localparam int ITEMS_PER_PHASE = 130;
    // Long receiver hold-off, in cycles, so that the block backs up.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Extra wait at the end, longer than a store item takes through the block.
    localparam int TAIL_CYCLES = 80;

    // One result item as the block reports it.
    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic signed [TEMP_W-1:0] min_v;
        logic signed [TEMP_W-1:0] max_v;
        logic signed [TEMP_W-1:0] avg;
        logic [COUNT_W-1:0]       count;
        t_event                   ev;
    } t_stats_report;

    // Keeps a private copy of the day records, the alarm latch and the
    // settings, computes the report each accepted item should produce and
    // checks the reports that come back against them in order.
    class day_stats_tracker;
        int          day_min_r   [NUM_DAYS_DEF];
        int          day_max_r   [NUM_DAYS_DEF];
        int          day_total_r [NUM_DAYS_DEF];
        int unsigned day_count_r [NUM_DAYS_DEF];
        int          day_avg_r   [NUM_DAYS_DEF];
        bit          alarm_on = 1'b0;
        int          low_lim = 0;
        int          high_lim = 400;
        bit          latched = 1'b0;
        int unsigned mismatches = 0;
        int unsigned report_no = 0;
        t_stats_report pending_reports[$];

        function void set_register(logic [CFG_IDX_W-1:0] idx,
                                   logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALARM_EN: alarm_on = data[0];
                CFG_LOW_LIM:  low_lim  = int'($signed(data));
                CFG_HIGH_LIM: high_lim = int'($signed(data));
                default: ;
            endcase
        endfunction

        function void log_sample(logic op, logic [DAY_W-1:0] day,
                                 logic [TICK_W-1:0] ticks);
            t_stats_report r;
            int celsius16;
            int d;
            r.temp  = '0;
            r.min_v = '0;
            r.max_v = '0;
            r.avg   = '0;
            r.count = '0;
            r.ev    = EV_NONE;
            if (op == OP_CLEAR) begin
                // The latch survives a clear; only the day records go.
                foreach (day_count_r[i]) begin
                    day_min_r[i]   = 0;
                    day_max_r[i]   = 0;
                    day_total_r[i] = 0;
                    day_count_r[i] = 0;
                    day_avg_r[i]   = 0;
                end
                pending_reports.push_back(r);
                return;
            end
            celsius16 = int'(ticks) * 16 / TICKS_PER_KELVIN - KELVIN_OFFSET;
            r.temp = celsius16[TEMP_W-1:0];
            if (int'(day) >= NUM_DAYS_DEF) begin
                pending_reports.push_back(r);
                return;
            end
            d = int'(day);
            if (day_count_r[d] == 0) begin
                day_max_r[d] = 0;
                day_min_r[d] = FIRST_MIN;
            end
            if (alarm_on) begin
                if (celsius16 < low_lim && !latched) begin
                    r.ev = EV_COLD;
                    latched = 1'b1;
                end else if (celsius16 > high_lim && !latched) begin
                    r.ev = EV_HOT;
                    latched = 1'b1;
                end else if (latched && celsius16 < high_lim && celsius16 > low_lim) begin
                    r.ev = EV_CLEAR;
                    latched = 1'b0;
                end
            end
            if (celsius16 > day_max_r[d]) day_max_r[d] = celsius16;
            if (celsius16 < day_min_r[d]) day_min_r[d] = celsius16;
            if (day_count_r[d] < COUNT_MAX) begin
                day_total_r[d] += celsius16;
                day_count_r[d] += 1;
            end
            day_avg_r[d] = day_total_r[d] / int'(day_count_r[d]);
            r.min_v = day_min_r[d][TEMP_W-1:0];
            r.max_v = day_max_r[d][TEMP_W-1:0];
            r.avg   = day_avg_r[d][TEMP_W-1:0];
            r.count = day_count_r[d][COUNT_W-1:0];
            pending_reports.push_back(r);
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void compare_report(t_stats_report got);
            t_stats_report want;
            report_no++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report %0d arrived with none expected: temp %0d", report_no,
                             got.temp);
                return;
            end
            want = pending_reports.pop_front();
            if (got.temp !== want.temp || got.min_v !== want.min_v ||
                got.max_v !== want.max_v || got.avg !== want.avg ||
                got.count !== want.count || got.ev !== want.ev) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("report %0d expected temp %0d min %0d max %0d avg %0d count %0d ev %0d",
                             report_no, want.temp, want.min_v, want.max_v, want.avg,
                             want.count, want.ev);
                    $display("report %0d actual   temp %0d min %0d max %0d avg %0d count %0d ev %0d",
                             report_no, got.temp, got.min_v, got.max_v, got.avg,
                             got.count, got.ev);
                end
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_opcode;
    logic [DAY_W-1:0]         i_day_index;
    logic [TICK_W-1:0]        i_pulse_ticks;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [TEMP_W-1:0] o_temp_value;
    logic signed [TEMP_W-1:0] o_day_min;
    logic signed [TEMP_W-1:0] o_day_max;
    logic signed [TEMP_W-1:0] o_day_average;
    logic [COUNT_W-1:0]       o_day_count;
    logic [1:0]               o_warning_event;

    day_stats_tracker book;

    // When set, neither side idles. The stimulus sets stall_request to make
    // the receiver hold off for a long stretch on its own.
    bit calm;
    bit stall_request;

    daily_temperature_stats_alarm u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_day_index     (i_day_index),
        .i_pulse_ticks   (i_pulse_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_temp_value    (o_temp_value),
        .o_day_min       (o_day_min),
        .o_day_max       (o_day_max),
        .o_day_average   (o_day_average),
        .o_day_count     (o_day_count),
        .o_warning_event (o_warning_event)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Smallest pulse width that converts to the given temperature. The
    // target is clamped to the range the conversion can produce.
    function automatic logic [TICK_W-1:0] ticks_for(int celsius16);
        int t;
        t = celsius16;
        if (t < -KELVIN_OFFSET) t = -KELVIN_OFFSET;
        if (t > 5616) t = 5616;
        return TICK_W'(((t + KELVIN_OFFSET) * TICKS_PER_KELVIN + 15) / 16);
    endfunction

    // Writes one register at the next rising edge. The caller lowers the
    // write enable once its burst of writes is done.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        book.set_register(idx, data);
    endtask

    // Only called while nothing is in flight. The enable register looks at
    // bit 0 alone, so its upper bits carry noise.
    task automatic apply_settings(bit en, int lo, int hi);
        write_reg(CFG_ALARM_EN, {13'($urandom), en});
        write_reg(CFG_LOW_LIM, CFG_DATA_W'(lo));
        write_reg(CFG_HIGH_LIM, CFG_DATA_W'(hi));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one item after a random gap and holds it until it is taken.
    task automatic send_item(logic op, logic [DAY_W-1:0] day, logic [TICK_W-1:0] ticks);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_day_index   <= day;
        i_pulse_ticks <= ticks;
        do @(posedge i_clk); while (!o_in_ready);
        book.log_sample(op, day, ticks);
    endtask

    // The sender stops and waits until every expected report has come back,
    // which also leaves the block idle for register writes.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    // A sample whose temperature lands close to one of the limits, so the
    // alarm latch keeps changing, with some noise around it.
    task automatic send_random_item(int lo, int hi, inout int counted);
        int pick;
        int target;
        logic [DAY_W-1:0] day;
        pick = $urandom_range(0, 99);
        day  = DAY_W'($urandom_range(0, NUM_DAYS_DEF - 1));
        if (pick < 3) begin
            send_item(OP_CLEAR, DAY_W'($urandom), TICK_W'($urandom));
        end else if (pick < 10) begin
            send_item(OP_STORE, DAY_W'(NUM_DAYS_DEF), TICK_W'($urandom));
        end else if (pick < 40) begin
            send_item(OP_STORE, day, TICK_W'($urandom));
            counted++;
        end else begin
            target = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 80)) - 40;
            send_item(OP_STORE, day, ticks_for(target));
            counted++;
        end
    endtask

    task automatic run_phase(bit en, int lo, int hi, bit calm_phase, bit stall_phase);
        int counted;
        counted = 0;
        apply_settings(en, lo, hi);
        calm = calm_phase;
        if (stall_phase) stall_request = 1'b1;
        while (counted < ITEMS_PER_PHASE) send_random_item(lo, hi, counted);
        wait_drained();
        calm = 1'b0;
    endtask

    // Receiver: random back-pressure, or one long hold-off on request while
    // the sender keeps offering items.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                stall_request = 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    // Every result item taken by the receiver is checked at the edge that
    // accepts it.
    initial begin
        t_stats_report got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.temp  = o_temp_value;
                got.min_v = o_day_min;
                got.max_v = o_day_max;
                got.avg   = o_day_average;
                got.count = o_day_count;
                got.ev    = t_event'(o_warning_event);
                book.compare_report(got);
            end
        end
    end

    // Watchdog: any accepted item on either channel restarts the count.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int lo;
        int hi;
        book          = new();
        calm          = 1'b0;
        stall_request = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_STORE;
        i_day_index   = '0;
        i_pulse_ticks = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: alarm off. Coldest and hottest readings on a fresh
        // day, a day out of range, exactly zero degrees, then a clear and a
        // fresh first sample after it.
        send_item(OP_STORE, 3'd0, 17'd0);
        send_item(OP_STORE, 3'd0, 17'h1FFFF);
        send_item(OP_STORE, DAY_W'(NUM_DAYS_DEF), ticks_for(0));
        send_item(OP_STORE, 3'd6, ticks_for(0));
        send_item(OP_CLEAR, 3'd0, 17'd0);
        send_item(OP_STORE, 3'd0, 17'd1000);
        wait_drained();

        // Alarm between 0 and 25 degrees: each event, values equal to a
        // limit, the latch holding across a clear item, and no check for a
        // day out of range.
        apply_settings(1'b1, 0, 400);
        send_item(OP_STORE, 3'd1, ticks_for(200));
        send_item(OP_STORE, 3'd1, ticks_for(-16));
        send_item(OP_STORE, 3'd1, ticks_for(-100));
        send_item(OP_STORE, 3'd1, ticks_for(0));
        send_item(OP_STORE, 3'd1, ticks_for(100));
        send_item(OP_STORE, 3'd2, ticks_for(401));
        send_item(OP_STORE, 3'd2, ticks_for(400));
        send_item(OP_CLEAR, 3'd2, 17'd12345);
        send_item(OP_STORE, 3'd2, ticks_for(500));
        send_item(OP_STORE, 3'd3, ticks_for(399));
        send_item(OP_STORE, DAY_W'(NUM_DAYS_DEF), 17'd0);
        send_item(OP_STORE, 3'd5, 17'h1FFFF);
        send_item(OP_CLEAR, DAY_W'(NUM_DAYS_DEF), 17'h1FFFF);
        send_item(OP_STORE, 3'd5, ticks_for(10));
        wait_drained();

        // Limits in the wrong order are compared literally.
        apply_settings(1'b1, 300, -300);
        send_item(OP_STORE, 3'd4, ticks_for(0));
        send_item(OP_STORE, 3'd4, ticks_for(500));
        wait_drained();

        // Widest limits: neither end of the range is outside them.
        apply_settings(1'b1, -KELVIN_OFFSET, 5616);
        send_item(OP_STORE, 3'd4, 17'd0);
        send_item(OP_STORE, 3'd4, ticks_for(0));
        send_item(OP_STORE, 3'd4, 17'h1FFFF);
        wait_drained();

        // Random phases, each under its own settings. The first one starts
        // with the long receiver hold-off, the third one never idles.
        run_phase(1'b1, 0, 400, 1'b0, 1'b1);
        lo = int'($urandom_range(0, 9986)) - KELVIN_OFFSET;
        hi = int'($urandom_range(0, 9986)) - KELVIN_OFFSET;
        run_phase(1'b0, lo, hi, 1'b0, 1'b0);
        run_phase(1'b1, -KELVIN_OFFSET, 5616, 1'b1, 1'b0);
        run_phase(1'b1, 5616, -KELVIN_OFFSET, 1'b0, 1'b0);
        lo = int'($urandom_range(0, 4000)) - KELVIN_OFFSET;
        hi = lo + int'($urandom_range(0, 5986));
        run_phase(1'b1, lo, hi, 1'b0, 1'b0);
        lo = int'($urandom_range(0, 9986)) - KELVIN_OFFSET;
        run_phase(1'b1, lo, lo, 1'b0, 1'b0);

        // Everything has come back; give the block time to show any stray
        // result before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/dts_pkg.sv
sv/dts_div.sv
sv/daily_temperature_stats_alarm.sv
sv/dts_checker.sv
tb/testbench.sv
